// ----- design/pvls_pkg.sv -----
// ----------------------------------------------------------------------------
// Valve lock sequencer package
// Item types, configuration types, reset values and the servo angle table.
// ----------------------------------------------------------------------------
package pvls_pkg;

	localparam int PHASE_COUNT = 4;
	localparam int PHASE_W     = $clog2(PHASE_COUNT);
	localparam int TIME_W      = 16;
	localparam int ANGLE_W     = 8;
	localparam int CFG_IDX_W   = 2;

	// Phases by name.
	localparam logic [PHASE_W-1:0] PH_FIRST  = 2'd0;
	localparam logic [PHASE_W-1:0] PH_SECOND = 2'd1;
	localparam logic [PHASE_W-1:0] PH_THIRD  = 2'd2;
	localparam logic [PHASE_W-1:0] PH_FOURTH = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_TIME_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_TIME_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME_FOURTH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TIME     = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [TIME_W-1:0] RST_OPEN_TIME_FIRST  = 16'd16000;
	localparam logic [TIME_W-1:0] RST_OPEN_TIME_SECOND = 16'd8000;
	localparam logic [TIME_W-1:0] RST_HOLD_TIME_FOURTH = 16'd4000;
	localparam logic [TIME_W-1:0] RST_RELEASE_TIME     = 16'd2000;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	typedef struct packed {
		logic start_req;
		logic pin_changed;
		logic timer_tick;
	} in_item_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] servo_angle;
		logic               valve_open;
		logic               busy_res;
		logic [PHASE_W-1:0] current_phase;
	} out_item_t;

	typedef struct packed {
		logic [TIME_W-1:0] open_time_first;
		logic [TIME_W-1:0] open_time_second;
		logic [TIME_W-1:0] hold_time_fourth;
		logic [TIME_W-1:0] release_time;
	} cfg_t;

	// Fixed servo angle for each phase.
	function automatic logic [ANGLE_W-1:0] servo_angle_of(input logic [PHASE_W-1:0] ph);
		logic [ANGLE_W-1:0] a;
		case (ph)
			PH_FIRST:  a = 8'd10;
			PH_SECOND: a = 8'd60;
			PH_THIRD:  a = 8'd120;
			PH_FOURTH: a = 8'd120;
			default:   a = 8'd120;
		endcase
		return a;
	endfunction

endpackage

// ----- design/pvls_chan_if.sv -----
// ----------------------------------------------------------------------------
// Valve lock sequencer channel
// Valid/ready channel carrying one item of the given payload type.
// ----------------------------------------------------------------------------
interface pvls_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/pvls_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Valve lock sequencer configuration registers
// Four 16-bit timing registers written through a plain write port.
// ----------------------------------------------------------------------------
module pvls_cfg_regs
	import pvls_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// Register file write; every index maps to one register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_time_first  <= RST_OPEN_TIME_FIRST;
			cfg_q.open_time_second <= RST_OPEN_TIME_SECOND;
			cfg_q.hold_time_fourth <= RST_HOLD_TIME_FOURTH;
			cfg_q.release_time     <= RST_RELEASE_TIME;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OPEN_TIME_FIRST:  cfg_q.open_time_first  <= cfg_data;
				REG_OPEN_TIME_SECOND: cfg_q.open_time_second <= cfg_data;
				REG_HOLD_TIME_FOURTH: cfg_q.hold_time_fourth <= cfg_data;
				REG_RELEASE_TIME:     cfg_q.release_time     <= cfg_data;
				default:              cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- design/pvls_core.sv -----
// ----------------------------------------------------------------------------
// Valve lock sequencer core
// Sequence state and the evaluation of one item against it.
// ----------------------------------------------------------------------------
module pvls_core
	import pvls_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      eval_en,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output out_item_t result
);

	logic [TIME_W-1:0]  elapsed_q;
	logic [PHASE_W-1:0] phase_q;
	logic               busy_q;
	logic               air_q;
	logic               release_q;

	logic [TIME_W-1:0]  elapsed_d;
	logic [PHASE_W-1:0] phase_d;
	logic               busy_d;
	logic               air_d;
	logic               release_d;
	logic               valve;
	logic               air_done;
	logic [TIME_W-1:0]  elapsed_st;

	// Elapsed count as seen by the evaluation; a start clears it first.
	assign elapsed_st = (item.start_req && !busy_q) ? '0 : elapsed_q;

	// Air stage end condition for the current phase.
	always_comb begin
		case (phase_q)
			PH_FIRST:  air_done = elapsed_st > cfg.open_time_first;
			PH_SECOND: air_done = elapsed_st > cfg.open_time_second;
			PH_THIRD:  air_done = item.pin_changed;
			default:   air_done = elapsed_st > cfg.hold_time_fourth;
		endcase
	end

	// Start, then stage evaluation, then the timer tick.
	always_comb begin
		elapsed_d = elapsed_q;
		phase_d   = phase_q;
		busy_d    = busy_q;
		air_d     = air_q;
		release_d = release_q;
		valve     = 1'b0;

		if (item.start_req && !busy_q) begin
			busy_d    = 1'b1;
			air_d     = 1'b1;
			elapsed_d = '0;
		end

		if (busy_d && air_d) begin
			if (air_done) begin
				air_d     = 1'b0;
				release_d = 1'b1;
				elapsed_d = '0;
			end else begin
				valve = (phase_q != PH_FOURTH);
			end
		end

		if (busy_d && release_d) begin
			valve = 1'b0;
			if (elapsed_d > cfg.release_time) begin
				release_d = 1'b0;
				busy_d    = 1'b0;
				phase_d   = phase_q + 1'b1;
			end
		end

		// The counter saturates at its maximum.
		if (item.timer_tick && elapsed_d != TIME_MAX) begin
			elapsed_d = elapsed_d + 1'b1;
		end
	end

	// State advances only for an item taken into evaluation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			phase_q   <= '0;
			busy_q    <= 1'b0;
			air_q     <= 1'b0;
			release_q <= 1'b0;
		end else if (eval_en) begin
			elapsed_q <= elapsed_d;
			phase_q   <= phase_d;
			busy_q    <= busy_d;
			air_q     <= air_d;
			release_q <= release_d;
		end
	end

	always_comb begin
		result.servo_angle   = servo_angle_of(phase_q);
		result.valve_open    = valve;
		result.busy_res      = busy_d;
		result.current_phase = phase_q;
	end

endmodule

// ----- design/phased_valve_lock_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// Phased valve lock sequencer
// Four-phase pneumatic hold sequencer with servo angle and valve control.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  in_ch     sink       start_req, pin_changed, timer_tick
//  out_ch    source     servo_angle, valve_open, busy_res, current_phase
//  cfg_*     write      four 16-bit timing registers, index 0 to 3
//
//  One item per cycle while out_ch does not stall; an item passes the
//  input register, then the evaluation feeds the result register.
//  Reset brings the timing registers to their defaults and the sequence idle.
//  A stall on out_ch holds the result register and a full input register; in_ch stays ready while the
//  input register is empty or moves on in the same cycle.
// ----------------------------------------------------------------------------
module phased_valve_lock_sequencer_top
	import pvls_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	pvls_chan_if.sink            in_ch,
	pvls_chan_if.source          out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_data
);

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result_s2;
	logic      valid_s2;
	out_item_t result;
	logic      advance;
	logic      eval_en;

	pvls_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Pipeline handshake: both stages move together when the result slot frees; an empty input stage may also load.
	assign advance     = !valid_s2 || out_ch.ready;
	assign eval_en     = valid_s1 && advance;
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1 <= in_ch.payload;
		end
	end

	pvls_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.eval_en (eval_en),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (eval_en) begin
			result_s2 <= result;
		end
	end

	assign out_ch.valid   = valid_s2;
	assign out_ch.payload = result_s2;

endmodule
